@@ design/sitda_pkg.sv @@
// Shared types and constants for the signed integer to decimal ASCII converter.
package sitda_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned QUOT_W     = 29;

  localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'd48;
  localparam logic [VALUE_W-1:0] RADIX       = 32'd10;

  // ceil(2^35 / 10); (x * RECIP_10) >> 35 equals x / 10 for every 32-bit x.
  localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int unsigned        RECIP_SHIFT = 35;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIG  = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } sitda_state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic digit;
    logic emit_sign;
    logic emit_digit;
  } sitda_cmd_t;

  typedef struct packed {
    logic negative;
    logic quot_zero;
    logic last_digit;
    logic out_free;
  } sitda_stat_t;

endpackage

@@ design/sitda_ctrl.sv @@
// Controller state machine: sequences division steps and character output.
module sitda_ctrl
  import sitda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  sitda_stat_t stat,
  output sitda_cmd_t  cmd
);

  sitda_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIG;
      end
      ST_DIG: begin
        cmd.digit = 1'b1;
        if (stat.quot_zero) begin
          state_nxt = stat.negative ? ST_SIGN : ST_EMIT;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_SIGN: begin
        if (stat.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_digit = 1'b1;
          if (stat.last_digit) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ design/sitda_dp.sv @@
// Datapath: magnitude, reciprocal divide by ten, digit stack and output register.
module sitda_dp
  import sitda_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [VALUE_W-1:0]  in_value,
  input  sitda_cmd_t          cmd,
  output sitda_stat_t         stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHAR_W-1:0]   out_character,
  output logic                out_last
);

  logic [VALUE_W-1:0]   mag_r;
  logic                 neg_r;
  logic [2*VALUE_W-1:0] prod_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIGIT_W-1:0]   digits_r [MAX_DIGITS];
  logic                 out_valid_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic                 out_last_r;

  logic [QUOT_W-1:0]    quot;
  logic [VALUE_W-1:0]   quot_x10;
  logic [VALUE_W-1:0]   rem_full;
  logic [CNT_W-1:0]     rd_idx;
  logic                 emit;

  assign quot     = prod_r[2*VALUE_W-1:RECIP_SHIFT];
  assign quot_x10 = VALUE_W'(quot) * RADIX;
  assign rem_full = mag_r - quot_x10;
  assign rd_idx   = cnt_r - CNT_W'(1);
  assign emit     = cmd.emit_sign | cmd.emit_digit;

  assign stat.negative   = neg_r;
  assign stat.quot_zero  = (quot == '0);
  assign stat.last_digit = (cnt_r == CNT_W'(1));
  assign stat.out_free   = !out_valid_r || out_ready;

  // Magnitude of the most negative value is 2^31, which the unsigned negate yields.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= in_value[VALUE_W-1];
      mag_r <= in_value[VALUE_W-1] ? (~in_value + VALUE_W'(1)) : in_value;
    end else if (cmd.digit) begin
      mag_r <= VALUE_W'(quot);
    end
    if (cmd.mul) begin
      prod_r <= (2*VALUE_W)'(mag_r) * (2*VALUE_W)'(RECIP_10);
    end
  end

  // Digits are pushed least significant first and popped most significant first.
  always_ff @(posedge clk) begin
    if (cmd.digit) begin
      digits_r[rd_idx + CNT_W'(1)] <= rem_full[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
    end else if (cmd.digit) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end else if (cmd.emit_digit) begin
      cnt_r <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char_r <= ASCII_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char_r <= ASCII_ZERO + CHAR_W'(digits_r[rd_idx]);
      out_last_r <= (cnt_r == CNT_W'(1));
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

@@ design/signed_int_to_decimal_ascii.sv @@
// Top level of the signed 32-bit integer to decimal ASCII text converter.
//
// Usage: the input channel (in_valid, in_ready, in_value) takes one signed
// 32-bit integer per transfer. The output channel (out_valid, out_ready,
// out_character, out_last) returns its decimal text one character per
// transfer, most significant first, with a leading '-' for negative values
// and out_last set on the final digit. Runs are 1 to 11 characters long.
//
// Timing: after a transfer in, the datapath finds the digits one at a time,
// each by a registered 32x32 reciprocal multiply and then the remainder step.
// Characters then leave at one per cycle through the output register while
// the receiver does not stall. in_ready is high only while no item is in
// progress.
//
// Reset clears the controller and the output valid flag. When the receiver
// stalls, the current character is held in the output register and the
// controller waits until it has been taken.
module signed_int_to_decimal_ascii
  import sitda_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  out_character,
  output logic               out_last
);

  sitda_cmd_t  cmd;
  sitda_stat_t stat;

  sitda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sitda_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule
